/* design/rdc_pkg.sv */
// ============================================================================
// rdc_pkg - shared types and constants for the range distinct counter
// Field widths, default sizes, and the command and status groups that pass
// between the controller and the datapath.
// ============================================================================
package rdc_pkg;

    localparam int POS_W = 10;
    localparam int VAL_W = 16;
    localparam int OUT_W = 11;

    localparam int POSITIONS_DEF = 1024;
    localparam int VALUES_DEF    = 65536;

    localparam logic [OUT_W-1:0] COUNT_MAX = 11'd2047;

    // Window edge movement chosen for the next step of a query.
    typedef enum logic [2:0] {
        MOVE_NONE,
        MOVE_GROW_R,
        MOVE_GROW_L,
        MOVE_SHRINK_R,
        MOVE_SHRINK_L
    } move_t;

    typedef enum logic {
        SRC_STORE,
        SRC_ITEM
    } cnt_src_t;

    typedef enum logic {
        DIR_INC,
        DIR_DEC
    } dir_t;

    typedef struct packed {
        logic     clear;
        logic     capture;
        logic     plan;
        logic     vs_read;
        logic     vs_read_pos;
        logic     cnt_read;
        cnt_src_t cnt_src;
        logic     cnt_write;
        dir_t     cnt_dir;
        logic     win_step;
        logic     vs_write;
        logic     emit;
    } rdc_cmd_t;

    typedef struct packed {
        logic  clear_last;
        logic  is_query;
        logic  reversed;
        logic  write_ok;
        logic  in_window;
        move_t move;
        logic  out_free;
    } rdc_status_t;

endpackage

/* design/rdc_if.sv */
// ============================================================================
// rdc_if - handshake channels of the range distinct counter
// One interface for incoming items and one for results, each with a source
// and a sink view.
// ============================================================================
interface rdc_item_if;
    import rdc_pkg::*;

    logic             valid;
    logic             ready;
    logic             operation;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] right_end;
    logic [VAL_W-1:0] value;

    modport source (output valid, output operation, output position,
                    output right_end, output value, input ready);
    modport sink   (input valid, input operation, input position,
                    input right_end, input value, output ready);
endinterface

interface rdc_result_if;
    import rdc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] distinct_count;

    modport source (output valid, output distinct_count, input ready);
    modport sink   (input valid, input distinct_count, output ready);
endinterface

/* design/range_distinct_count_with_updates.sv */
// ============================================================================
// range_distinct_count_with_updates - distinct values in a position range
// Point writes into a value array and range queries that return how many
// distinct values the range holds, kept by a sliding window over the array.
// ============================================================================
//
//   channel   dir   payload                                     per transaction
//   -------   ---   -----------------------------------------   ----------------
//   item      in    operation, position, right_end, value       one write/query
//   result    out   distinct_count                              one per query
//
// After reset the block runs a clearing pass over both memories, one entry a
// cycle over max(POSITIONS, VALUES) entries (65536 at the default sizes), and
// accepts no item until it ends.
// A write outside the window only stores the value; one inside it also
// moves an occurrence from the old value to the new one. A query moves each
// edge one position per step over the distance it travels, each step costing
// a value store read, an occurrence table read and an occurrence table write
// in sequence. A reversed range gives 0 and leaves the window alone.
// The result register lets the next item be taken while a result waits; a
// query that finishes while the previous result is still held stalls there.
//
module range_distinct_count_with_updates #(
    parameter int POSITIONS = rdc_pkg::POSITIONS_DEF,
    parameter int VALUES    = rdc_pkg::VALUES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rdc_item_if.sink      item,
    rdc_result_if.source  result
);
    import rdc_pkg::*;

    rdc_cmd_t    cmd;
    rdc_status_t status;

    // The controller owns sequencing and the input handshake.
    rdc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath holds all storage, the window and the result register.
    rdc_datapath #(
        .POSITIONS (POSITIONS),
        .VALUES    (VALUES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .operation      (item.operation),
        .position       (item.position),
        .right_end      (item.right_end),
        .value          (item.value),
        .out_ready      (result.ready),
        .out_valid      (result.valid),
        .distinct_count (result.distinct_count)
    );

endmodule

/* design/rdc_ctrl.sv */
// ============================================================================
// rdc_ctrl - sequencing controller
// Runs the clearing pass, accepts items and steps the datapath through
// window moves and point writes.
// ============================================================================
module rdc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  rdc_pkg::rdc_status_t status,
    output rdc_pkg::rdc_cmd_t    cmd
);
    import rdc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_PLAN,
        S_M_CREAD,
        S_M_CWRITE,
        S_EMIT,
        S_W_VREAD,
        S_W_CREAD_OLD,
        S_W_CWRITE_OLD,
        S_W_CREAD_NEW,
        S_W_CWRITE_NEW,
        S_W_STORE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.is_query)
                    state_next = status.reversed ? S_EMIT : S_PLAN;
                else if (!status.write_ok)
                    state_next = S_IDLE;
                else if (status.in_window)
                    state_next = S_W_VREAD;
                else
                    state_next = S_W_STORE;
            end
            S_PLAN:
            begin
                if (status.move == MOVE_NONE)
                    state_next = S_EMIT;
                else
                begin
                    cmd.plan    = 1'b1;
                    cmd.vs_read = 1'b1;
                    state_next  = S_M_CREAD;
                end
            end
            S_M_CREAD:
            begin
                cmd.cnt_read = 1'b1;
                cmd.cnt_src  = SRC_STORE;
                state_next   = S_M_CWRITE;
            end
            S_M_CWRITE:
            begin
                cmd.cnt_write = 1'b1;
                cmd.win_step  = 1'b1;
                state_next    = S_PLAN;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_W_VREAD:
            begin
                cmd.vs_read     = 1'b1;
                cmd.vs_read_pos = 1'b1;
                state_next      = S_W_CREAD_OLD;
            end
            S_W_CREAD_OLD:
            begin
                cmd.cnt_read = 1'b1;
                cmd.cnt_src  = SRC_STORE;
                state_next   = S_W_CWRITE_OLD;
            end
            S_W_CWRITE_OLD:
            begin
                cmd.cnt_write = 1'b1;
                cmd.cnt_dir   = DIR_DEC;
                state_next    = S_W_CREAD_NEW;
            end
            S_W_CREAD_NEW:
            begin
                cmd.cnt_read = 1'b1;
                cmd.cnt_src  = SRC_ITEM;
                state_next   = S_W_CWRITE_NEW;
            end
            S_W_CWRITE_NEW:
            begin
                cmd.cnt_write = 1'b1;
                cmd.cnt_dir   = DIR_INC;
                state_next    = S_W_STORE;
            end
            S_W_STORE:
            begin
                cmd.vs_write = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

/* design/rdc_datapath.sv */
// ============================================================================
// rdc_datapath - value store, occurrence table and window registers
// Holds the captured item, both memories, the window edges, the distinct
// total and the result register.
// ============================================================================
module rdc_datapath #(
    parameter int POSITIONS = rdc_pkg::POSITIONS_DEF,
    parameter int VALUES    = rdc_pkg::VALUES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rdc_pkg::rdc_cmd_t          cmd,
    output rdc_pkg::rdc_status_t       status,
    input  logic                       operation,
    input  logic [rdc_pkg::POS_W-1:0]  position,
    input  logic [rdc_pkg::POS_W-1:0]  right_end,
    input  logic [rdc_pkg::VAL_W-1:0]  value,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [rdc_pkg::OUT_W-1:0]  distinct_count
);
    import rdc_pkg::*;

    localparam int PW        = $clog2(POSITIONS);
    localparam int WW        = $clog2(POSITIONS + 1);
    localparam int VW        = $clog2(VALUES);
    localparam int VE        = (VAL_W > $clog2(VALUES + 1)) ? VAL_W : $clog2(VALUES + 1);
    localparam int EW        = (POS_W > WW) ? POS_W : WW;
    localparam int CE        = (WW > OUT_W) ? WW : OUT_W;
    localparam int CLEAR_LEN = (POSITIONS > VALUES) ? POSITIONS : VALUES;
    localparam int CLW       = $clog2(CLEAR_LEN);
    localparam int CLE       = CLW + 1;

    // Captured item.
    logic             op_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] rgt_reg;
    logic [VAL_W-1:0] val_reg;

    // Window and running total.
    logic [WW-1:0] ws_reg;
    logic [WW-1:0] ws_next;
    logic [WW-1:0] we_reg;
    logic [WW-1:0] we_next;
    logic [WW-1:0] total_reg;
    logic [WW-1:0] total_next;
    move_t         move_reg;
    logic [CLW-1:0] clr_idx_reg;
    logic [CLW-1:0] clr_idx_next;

    // Result register.
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [OUT_W-1:0] out_data_reg;

    // Memories.
    logic [VAL_W-1:0] vs_mem [POSITIONS];
    logic [WW-1:0]    cnt_mem [VALUES];
    logic [VAL_W-1:0] vs_rdata_reg;
    logic [WW-1:0]    cnt_rdata_reg;
    logic [VW-1:0]    cnt_addr_reg;

    logic [EW-1:0]    pos_e;
    logic [EW-1:0]    rgt_e;
    logic [EW-1:0]    rgt_c;
    logic [WW-1:0]    left_w;
    logic [WW-1:0]    stop_w;
    move_t            move_now;
    logic [PW-1:0]    vs_raddr;
    logic [VW-1:0]    cnt_raddr;
    logic             vs_we;
    logic [PW-1:0]    vs_waddr;
    logic [VAL_W-1:0] vs_wdata;
    logic             cnt_we;
    logic [VW-1:0]    cnt_waddr;
    logic [WW-1:0]    cnt_wdata;
    logic [CLE-1:0]   clr_ext;
    dir_t             dir_eff;
    logic [OUT_W-1:0] sat_total;

    // Range decoding of the captured item.
    always_comb
    begin
        pos_e  = EW'(pos_reg);
        rgt_e  = EW'(rgt_reg);
        rgt_c  = (rgt_e >= EW'(POSITIONS)) ? EW'(POSITIONS - 1) : rgt_e;
        left_w = WW'(pos_e);
        stop_w = WW'(rgt_c) + WW'(1);

        if (we_reg < stop_w)
            move_now = MOVE_GROW_R;
        else if (ws_reg > left_w)
            move_now = MOVE_GROW_L;
        else if (we_reg > stop_w)
            move_now = MOVE_SHRINK_R;
        else if (ws_reg < left_w)
            move_now = MOVE_SHRINK_L;
        else
            move_now = MOVE_NONE;
    end

    assign sat_total = (CE'(total_reg) > CE'(COUNT_MAX)) ? COUNT_MAX : OUT_W'(total_reg);

    always_comb
    begin
        status.clear_last = (clr_idx_reg == CLW'(CLEAR_LEN - 1));
        status.is_query   = op_reg;
        status.reversed   = (pos_e > rgt_c);
        status.write_ok   = (pos_e < EW'(POSITIONS)) && (VE'(val_reg) < VE'(VALUES));
        status.in_window  = (pos_e >= EW'(ws_reg)) && (pos_e < EW'(we_reg));
        status.move       = move_now;
        status.out_free   = !out_valid_reg || out_ready;
    end

    // Read addresses.
    always_comb
    begin
        if (cmd.vs_read_pos)
            vs_raddr = PW'(pos_reg);
        else
        begin
            case (move_now)
                MOVE_GROW_R:   vs_raddr = PW'(we_reg);
                MOVE_GROW_L:   vs_raddr = PW'(ws_reg - WW'(1));
                MOVE_SHRINK_R: vs_raddr = PW'(we_reg - WW'(1));
                default:       vs_raddr = PW'(ws_reg);
            endcase
        end
        cnt_raddr = (cmd.cnt_src == SRC_STORE) ? VW'(vs_rdata_reg) : VW'(val_reg);
    end

    // Write ports, shared between the clearing pass and normal operation.
    always_comb
    begin
        clr_ext = {1'b0, clr_idx_reg};
        if (cmd.win_step)
            dir_eff = (move_reg == MOVE_GROW_R || move_reg == MOVE_GROW_L) ? DIR_INC
                                                                           : DIR_DEC;
        else
            dir_eff = cmd.cnt_dir;

        if (cmd.clear)
        begin
            vs_we     = (clr_ext < CLE'(POSITIONS));
            vs_waddr  = PW'(clr_idx_reg);
            vs_wdata  = '0;
            cnt_we    = (clr_ext < CLE'(VALUES));
            cnt_waddr = VW'(clr_idx_reg);
            cnt_wdata = '0;
        end
        else
        begin
            vs_we     = cmd.vs_write;
            vs_waddr  = PW'(pos_reg);
            vs_wdata  = val_reg;
            cnt_we    = cmd.cnt_write;
            cnt_waddr = cnt_addr_reg;
            if (dir_eff == DIR_INC)
                cnt_wdata = cnt_rdata_reg + WW'(1);
            else if (cnt_rdata_reg != '0)
                cnt_wdata = cnt_rdata_reg - WW'(1);
            else
                cnt_wdata = cnt_rdata_reg;
        end
    end

    // Next state of window, total and result.
    always_comb
    begin
        ws_next        = ws_reg;
        we_next        = we_reg;
        total_next     = total_reg;
        clr_idx_next   = cmd.clear ? clr_idx_reg + CLW'(1) : clr_idx_reg;
        out_valid_next = out_valid_reg;

        if (cmd.cnt_write)
        begin
            if (dir_eff == DIR_INC && cnt_rdata_reg == '0)
                total_next = total_reg + WW'(1);
            else if (dir_eff == DIR_DEC && cnt_rdata_reg == WW'(1) && total_reg != '0)
                total_next = total_reg - WW'(1);
        end

        if (cmd.win_step)
        begin
            case (move_reg)
                MOVE_GROW_R:   we_next = we_reg + WW'(1);
                MOVE_GROW_L:   ws_next = ws_reg - WW'(1);
                MOVE_SHRINK_R: we_next = we_reg - WW'(1);
                MOVE_SHRINK_L: ws_next = ws_reg + WW'(1);
                default:       ;
            endcase
        end

        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg        <= '0;
            we_reg        <= '0;
            total_reg     <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            move_reg      <= MOVE_NONE;
        end
        else
        begin
            ws_reg        <= ws_next;
            we_reg        <= we_next;
            total_reg     <= total_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
            if (cmd.plan)
                move_reg <= move_now;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            pos_reg <= position;
            rgt_reg <= right_end;
            val_reg <= value;
        end
        if (cmd.emit)
            out_data_reg <= status.reversed ? '0 : sat_total;
        if (cmd.cnt_read)
            cnt_addr_reg <= cnt_raddr;
    end

    // Value store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (vs_we)
            vs_mem[vs_waddr] <= vs_wdata;
        if (cmd.vs_read)
            vs_rdata_reg <= vs_mem[vs_raddr];
    end

    // Occurrence table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cmd.cnt_read)
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
    end

    assign out_valid      = out_valid_reg;
    assign distinct_count = out_data_reg;

    // The window never inverts and never runs past the array.
    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        (ws_reg <= we_reg) && (we_reg <= WW'(POSITIONS)))
        else $error("window edges out of order");

    // The distinct total cannot exceed the number of positions in the window.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= (we_reg - ws_reg))
        else $error("distinct total larger than window");

    // A value leaving the window must have been counted.
    a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cnt_write && dir_eff == DIR_DEC) |-> (cnt_rdata_reg != '0))
        else $error("removing a value with zero occurrences");

    // A result is never loaded over one that is still waiting.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

endmodule

/* verif/testbench.sv */
// ============================================================================
// testbench - range distinct counter with point writes
// Drives writes and range queries through the item channel and checks every
// distinct_count transaction against a cycle-free predictor of the window and
// the per-value occurrence table, or a typed count. A short directed table
// comes first, then random traffic kept mostly close to the current window.
// ============================================================================
module testbench;
    import rdc_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 10;
    localparam int RANDOM_ITEMS     = 830;
    localparam int CALM_TAIL        = 100;
    localparam int SEGMENT_ITEMS    = 100;
    localparam int LONG_HOLD_AT     = 250;
    localparam int LONG_HOLD_CYCLES = 500;
    localparam int SETTLE_CYCLES    = 200;
    localparam int LAST_POS         = POSITIONS_DEF - 1;
    localparam int EXPECT_DEPTH     = 1024;

    // The slowest correct run: every transaction a query that walks both edges
    // across the whole array, plus the longest gaps on both sides and the
    // clearing pass after reset, taken four times over.
    localparam longint unsigned RUN_LIMIT = 64'd12 * 64'd22_000_000;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic             op;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] rgt;
        logic [VAL_W-1:0] val;
    } request_t;

    // One row of the directed table. Where known_count is set, the expected
    // count is the one typed in the row rather than the predictor's.
    typedef struct {
        logic             op;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] rgt;
        logic [VAL_W-1:0] val;
        bit               known_count;
        logic [OUT_W-1:0] count;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 20;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // After reset every position holds zero: one distinct value.
        '{OP_QUERY, 10'd0,    10'd0,    16'h0000, 1'b1, 11'd1},
        '{OP_QUERY, 10'd0,    10'd1023, 16'h0000, 1'b1, 11'd1},
        // Reversed ranges give zero and leave the window where it was.
        '{OP_QUERY, 10'd5,    10'd3,    16'hFFFF, 1'b1, 11'd0},
        '{OP_QUERY, 10'd1023, 10'd0,    16'h0000, 1'b1, 11'd0},
        // Writes inside the full-array window.
        '{OP_WRITE, 10'd1023, 10'd1023, 16'hFFFF, 1'b0, 11'd0},
        '{OP_WRITE, 10'd0,    10'd0,    16'hAAAA, 1'b0, 11'd0},
        '{OP_WRITE, 10'd512,  10'd0,    16'h5555, 1'b0, 11'd0},
        '{OP_QUERY, 10'd0,    10'd1023, 16'h0000, 1'b1, 11'd4},
        '{OP_QUERY, 10'd1023, 10'd1023, 16'h0000, 1'b1, 11'd1},
        '{OP_WRITE, 10'd1023, 10'd512,  16'h0000, 1'b0, 11'd0},
        '{OP_QUERY, 10'd1023, 10'd1023, 16'h1234, 1'b0, 11'd0},
        // A write outside the window, then writes inside it.
        '{OP_WRITE, 10'd1,    10'd0,    16'h0007, 1'b0, 11'd0},
        '{OP_QUERY, 10'd0,    10'd2,    16'h0000, 1'b0, 11'd0},
        '{OP_WRITE, 10'd2,    10'd0,    16'h0007, 1'b0, 11'd0},
        '{OP_QUERY, 10'd1,    10'd2,    16'h0000, 1'b0, 11'd0},
        '{OP_QUERY, 10'd511,  10'd513,  16'h0000, 1'b0, 11'd0},
        '{OP_QUERY, 10'd0,    10'd1023, 16'h0000, 1'b0, 11'd0},
        '{OP_WRITE, 10'd700,  10'd0,    16'h5555, 1'b0, 11'd0},
        '{OP_QUERY, 10'd300,  10'd800,  16'h0000, 1'b0, 11'd0},
        '{OP_QUERY, 10'd0,    10'd0,    16'h0000, 1'b0, 11'd0}
    };

    logic clk;
    logic rst_n;

    rdc_item_if   item_ch ();
    rdc_result_if result_ch ();

    range_distinct_count_with_updates #(
        .POSITIONS (POSITIONS_DEF),
        .VALUES    (VALUES_DEF)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // ------------------------------------------------------------------------
    // Predictor state. It mirrors the block's memories and window registers,
    // and it is advanced once for every item transaction, at the edge where
    // that transaction is accepted. Bit arrays start at zero, which matches
    // the state left behind by the clearing pass.
    // ------------------------------------------------------------------------
    bit   [VAL_W-1:0] stored_value [POSITIONS_DEF];
    bit   [OUT_W-1:0] value_tally  [VALUES_DEF];
    logic [POS_W:0]   win_lo = '0;        // first position inside the window
    logic [POS_W:0]   win_hi = '0;        // first position past the window
    logic [OUT_W-1:0] distinct_now = '0;

    // Expected counts in arrival order, written by the sender and read by the
    // checker.
    logic [OUT_W-1:0] expected_counts [EXPECT_DEPTH];
    int               expect_wr  = 0;
    int               expect_rd  = 0;
    int               mismatches = 0;

    // Shared between the two stimulus processes.
    bit gaps_on           = 1'b1;
    bit long_hold_pending = 1'b0;
    bit hold_active       = 1'b0;

    function automatic void tally_add(input logic [VAL_W-1:0] v);
        value_tally[v] = value_tally[v] + 1'b1;
        if (value_tally[v] == 1)
            distinct_now = distinct_now + 1'b1;
    endfunction

    function automatic void tally_remove(input logic [VAL_W-1:0] v);
        if (value_tally[v] != 0)
        begin
            value_tally[v] = value_tally[v] - 1'b1;
            if (value_tally[v] == 0 && distinct_now != 0)
                distinct_now = distinct_now - 1'b1;
        end
    endfunction

    // Applies one accepted request to the predictor. Returns 1 when the
    // request produces a result transaction, with the count in count.
    // With 1024 positions and 16-bit values no write is out of range, the
    // right end never needs clamping and the total never saturates.
    function automatic bit count_distinct(input request_t req,
                                          output logic [OUT_W-1:0] count);
        logic [POS_W:0] stop;

        count = '0;
        if (req.op == OP_WRITE)
        begin
            if ({1'b0, req.pos} >= win_lo && {1'b0, req.pos} < win_hi)
            begin
                tally_remove(stored_value[req.pos]);
                tally_add(req.val);
            end
            stored_value[req.pos] = req.val;
            return 1'b0;
        end

        if (req.pos > req.rgt)
            return 1'b1;

        // The edges move in the same order as in the block: grow right,
        // grow left, shrink right, shrink left.
        stop = {1'b0, req.rgt} + 1'b1;
        while (win_hi < stop)
        begin
            tally_add(stored_value[win_hi[POS_W-1:0]]);
            win_hi = win_hi + 1'b1;
        end
        while (win_lo > {1'b0, req.pos})
        begin
            win_lo = win_lo - 1'b1;
            tally_add(stored_value[win_lo[POS_W-1:0]]);
        end
        while (win_hi > stop)
        begin
            win_hi = win_hi - 1'b1;
            tally_remove(stored_value[win_hi[POS_W-1:0]]);
        end
        while (win_lo < {1'b0, req.pos})
        begin
            tally_remove(stored_value[win_lo[POS_W-1:0]]);
            win_lo = win_lo + 1'b1;
        end
        count = distinct_now;
        return 1'b1;
    endfunction

    // Random requests are drawn against the predictor's window, so that most
    // queries move the edges only a short way and most writes land inside
    // the window where they disturb the occurrence table. A few queries jump to
    // a random range anywhere in the array, and a few are reversed.
    function automatic request_t pick_request();
        request_t req;
        int       roll;
        int       lo;
        int       hi;

        req.op  = OP_WRITE;
        req.pos = POS_W'($urandom_range(0, LAST_POS));
        req.rgt = POS_W'($urandom_range(0, LAST_POS));
        req.val = VAL_W'($urandom_range(0, 65535));
        roll    = $urandom_range(0, 99);

        if (roll < 45)
        begin
            if (win_hi > win_lo && $urandom_range(0, 9) < 7)
                req.pos = POS_W'($urandom_range(int'(win_lo), int'(win_hi) - 1));
            // A small set of values keeps repeats, and so the counts, lively.
            if ($urandom_range(0, 4) != 0)
                req.val = VAL_W'($urandom_range(0, 15));
        end
        else
        begin
            req.op = OP_QUERY;
            if (roll < 50)
            begin
                lo      = $urandom_range(1, LAST_POS);
                req.pos = POS_W'(lo);
                req.rgt = POS_W'($urandom_range(0, lo - 1));
            end
            else if (roll < 53)
            begin
                lo      = $urandom_range(0, LAST_POS);
                req.pos = POS_W'(lo);
                req.rgt = POS_W'($urandom_range(lo, LAST_POS));
            end
            else
            begin
                lo = int'(win_lo) + int'($urandom_range(0, 64)) - 32;
                if (lo < 0)
                    lo = 0;
                if (lo > LAST_POS)
                    lo = LAST_POS;
                hi = lo + int'($urandom_range(0, 48));
                if (hi > LAST_POS)
                    hi = LAST_POS;
                req.pos = POS_W'(lo);
                req.rgt = POS_W'(hi);
            end
        end
        return req;
    endfunction

    // Offers one request, holding it until the block takes it; for a query it
    // then records what the result should carry. An idle burst may come first.
    task automatic offer_request(input request_t req, input bit known_count,
                                 input logic [OUT_W-1:0] typed_count);
        int unsigned      gap;
        logic [OUT_W-1:0] count;

        if (gaps_on && !hold_active && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            repeat (gap)
            begin
                @(negedge clk);
                item_ch.valid <= 1'b0;
            end
        end
        @(negedge clk);
        item_ch.valid     <= 1'b1;
        item_ch.operation <= req.op;
        item_ch.position  <= req.pos;
        item_ch.right_end <= req.rgt;
        item_ch.value     <= req.val;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        if (count_distinct(req, count))
        begin
            expected_counts[expect_wr % EXPECT_DEPTH] = known_count ? typed_count : count;
            expect_wr++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset. Reset is held low and released on a falling edge; the
    // block then runs its clearing pass with ready low, which the first
    // transaction simply waits out.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Result side. Ready changes on falling edges. It drops in random bursts
    // while gaps are enabled, and once, on request from the sender, it stays
    // low for a long stretch so that the result register fills, the next
    // query stalls behind it and the item channel backs up.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned hold;

        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                hold_active       = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
                hold_active = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 19);
                result_ch.ready <= 1'b0;
                repeat (hold - 1) @(negedge clk);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checking. Every accepted result transaction is compared with the
    // oldest outstanding expectation; a transaction with nothing outstanding
    // is a failure in its own right.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [OUT_W-1:0] wanted;

        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                if (expect_rd == expect_wr)
                begin
                    $display("%0t: distinct_count %0d arrived with no query outstanding",
                             $time, result_ch.distinct_count);
                    mismatches++;
                end
                else
                begin
                    wanted = expected_counts[expect_rd % EXPECT_DEPTH];
                    expect_rd++;
                    if (result_ch.distinct_count !== wanted)
                    begin
                        $display("%0t: distinct_count mismatch: expected %0d, got %0d",
                                 $time, wanted, result_ch.distinct_count);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item side: the directed table, then random traffic in segments that
    // switch idling on or off, with a calm tail where neither side idles.
    // ------------------------------------------------------------------------
    initial
    begin
        request_t req;

        item_ch.valid     = 1'b0;
        item_ch.operation = OP_WRITE;
        item_ch.position  = '0;
        item_ch.right_end = '0;
        item_ch.value     = '0;
        wait (rst_n === 1'b1);

        foreach (directed_rows[i])
        begin
            req.op  = directed_rows[i].op;
            req.pos = directed_rows[i].pos;
            req.rgt = directed_rows[i].rgt;
            req.val = directed_rows[i].val;
            offer_request(req, directed_rows[i].known_count, directed_rows[i].count);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n >= RANDOM_ITEMS - CALM_TAIL)
                gaps_on = 1'b0;
            else if (n % SEGMENT_ITEMS == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            if (n == LONG_HOLD_AT)
                long_hold_pending = 1'b1;
            offer_request(pick_request(), 1'b0, '0);
        end

        @(negedge clk);
        item_ch.valid <= 1'b0;

        // Writes produce no result, so the bench waits for the last count and
        // then settles, to catch anything unexpected.
        while (expect_rd != expect_wr)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
